// ===== design/sca_pkg.sv =====
// shared types, constants and helper functions for the size class allocator
// no dependencies

`default_nettype none

package sca_pkg;

  localparam int unsigned SIZE_W      = 64;
  localparam int unsigned CLASS_W     = 8;
  localparam int unsigned SLOT_W      = 56;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned SMALL_LIMIT = 1024;
  localparam int unsigned SMALL_LOG   = 10;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TOO_LARGE    = 3'd1,
    ST_OVERFLOW     = 3'd2,
    ST_FREE_IGNORED = 3'd3,
    ST_LIST_FULL    = 3'd4
  } sca_status_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } sca_req_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic map;
    logic fetch;
    logic commit;
  } sca_cmd_t;

  function automatic logic [POS_W-1:0] top_bit(logic [SIZE_W-1:0] v);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (v[i]) p = POS_W'(i);
    end
    return p;
  endfunction

  function automatic logic [SIZE_W-1:0] class_size(logic [CLASS_W-1:0] cls);
    logic [SIZE_W-1:0] base;
    base = SIZE_W'(SMALL_LIMIT) | {{(SIZE_W-10){1'b0}}, cls[1:0], 8'h00};
    return base << cls[CLASS_W-1:2];
  endfunction

endpackage

`default_nettype wire

// ===== design/sca_if.sv =====
// request and response channel interfaces for the size class allocator
// depends on sca_pkg

`default_nettype none

interface sca_req_if;
  import sca_pkg::*;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [SIZE_W-1:0] alloc_size;
  logic [SIZE_W-1:0] free_handle;

  modport source (output valid, output req_type, output alloc_size, output free_handle,
                  input ready);
  modport sink   (input valid, input req_type, input alloc_size, input free_handle,
                  output ready);
endinterface

interface sca_rsp_if;
  import sca_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] handle;
  logic [SIZE_W-1:0] rounded_size;
  sca_status_e       status;

  modport source (output valid, output handle, output rounded_size, output status,
                  input ready);
  modport sink   (input valid, input handle, input rounded_size, input status,
                  output ready);
endinterface

`default_nettype wire

// ===== design/sca_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies

`default_nettype none

module sca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/sca_ctrl.sv =====
// sequencing state machine and result handshake for the size class allocator
// depends on sca_pkg

`default_nettype none

module sca_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_ready_o,
  output logic                   rsp_valid_o,
  input  wire logic              rsp_ready_i,
  output sca_pkg::sca_cmd_t      cmd_o
);
  import sca_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_MAP    = 5'b00100,
    S_FETCH  = 5'b01000,
    S_COMMIT = 5'b10000
  } sca_state_e;

  sca_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || rsp_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = req_valid_i;
        if (req_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        state_d    = S_MAP;
      end
      S_MAP: begin
        cmd_o.map = 1'b1;
        state_d   = S_FETCH;
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = slot_free;
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== design/sca_dp.sv =====
// datapath: size to class mapping, per-class metadata, free lists, result register
// depends on sca_pkg and sca_ram

`default_nettype none

module sca_dp #(
  parameter int unsigned NUM_CLASSES = 160,
  parameter int unsigned LIST_DEPTH  = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire sca_pkg::sca_cmd_t          cmd_i,
  input  wire logic                       req_type_i,
  input  wire logic [sca_pkg::SIZE_W-1:0] alloc_size_i,
  input  wire logic [sca_pkg::SIZE_W-1:0] free_handle_i,
  output logic      [sca_pkg::SIZE_W-1:0] handle_o,
  output logic      [sca_pkg::SIZE_W-1:0] rounded_size_o,
  output sca_pkg::sca_status_e            status_o
);
  import sca_pkg::*;

  localparam int unsigned CLS_IW     = $clog2(NUM_CLASSES);
  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned SLOT_DEPTH = NUM_CLASSES * LIST_DEPTH;
  localparam int unsigned SLOT_AW    = $clog2(SLOT_DEPTH);
  localparam int unsigned META_W     = SIZE_W + CNT_W;

  // request capture
  logic              free_q;
  logic              small_q;
  logic [SIZE_W-1:0] arg_q;
  logic [POS_W-1:0]  pos_q;

  // class mapping
  logic [CLASS_W-1:0] cls_d, cls_q;
  logic               valid_d, valid_q;
  logic [POS_W-1:0]   a_w;
  logic [POS_W-1:0]   sh_w;
  logic [SIZE_W-1:0]  shifted;
  logic [CLS_IW-1:0]  cls_idx;

  // per-class state
  logic [NUM_CLASSES-1:0] opened_q;
  logic                   opened_now, opened_q2;
  logic [META_W-1:0]      meta_rdata, meta_wdata;
  logic                   meta_we;
  logic [CNT_W-1:0]       cnt_eff, cnt_dec, cnt_q, cnt_new;
  logic [SIZE_W-1:0]      off_eff, off_q, off_new;
  logic [SIZE_W-1:0]      rsz_q;

  // free list store
  logic [SLOT_AW-1:0] slot_base;
  logic [SLOT_AW-1:0] slot_raddr, slot_waddr;
  logic [SLOT_W-1:0]  slot_rdata;
  logic               slot_we;

  // result
  logic [SIZE_W-1:0] hnd_d, rsz_d;
  sca_status_e       st_d;
  logic              open_set;
  logic [SIZE_W-1:0] hnd_q, rsz_out_q;
  sca_status_e       st_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      free_q  <= req_type_i;
      small_q <= (alloc_size_i <= SIZE_W'(SMALL_LIMIT));
      arg_q   <= (req_type_i == REQ_FREE) ? free_handle_i : (alloc_size_i - SIZE_W'(1));
    end
    if (cmd_i.scan) pos_q <= top_bit(arg_q);
  end

  assign a_w     = pos_q - POS_W'(SMALL_LOG);
  assign sh_w    = pos_q - POS_W'(2);
  assign shifted = arg_q >> sh_w;

  always_comb begin
    if (free_q) begin
      cls_d = arg_q[CLASS_W-1:0];
    end else if (small_q) begin
      cls_d = '0;
    end else begin
      cls_d = {a_w, shifted[1:0]} + CLASS_W'(1);
    end
  end

  assign valid_d = ({1'b0, cls_d} < (CLASS_W + 1)'(NUM_CLASSES));

  always_ff @(posedge clk_i) begin
    if (cmd_i.map) begin
      cls_q   <= cls_d;
      valid_q <= valid_d;
    end
  end

  assign cls_idx = cls_q[CLS_IW-1:0];

  sca_ram #(
    .WIDTH (META_W),
    .DEPTH (NUM_CLASSES)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (cls_idx),
    .wdata_i (meta_wdata),
    .re_i    (cmd_i.map),
    .raddr_i (cls_d[CLS_IW-1:0]),
    .rdata_o (meta_rdata)
  );

  // metadata is only meaningful once the class has been opened
  assign opened_now = valid_q ? opened_q[cls_idx] : 1'b0;
  assign cnt_eff    = opened_now ? meta_rdata[CNT_W-1:0] : '0;
  assign off_eff    = opened_now ? meta_rdata[META_W-1:CNT_W] : '0;
  assign cnt_dec    = cnt_eff - CNT_W'(1);
  assign slot_base  = SLOT_AW'(cls_idx) * SLOT_AW'(LIST_DEPTH);
  assign slot_raddr = slot_base + SLOT_AW'(cnt_dec[IDX_W-1:0]);
  assign slot_waddr = slot_base + SLOT_AW'(cnt_q[IDX_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      opened_q2 <= opened_now;
      cnt_q     <= cnt_eff;
      off_q     <= off_eff;
      rsz_q     <= class_size(cls_q);
    end
  end

  sca_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOT_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (arg_q[SIZE_W-1:CLASS_W]),
    .re_i    (cmd_i.fetch),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  always_comb begin
    hnd_d    = '1;
    rsz_d    = '0;
    st_d     = ST_OK;
    open_set = 1'b0;
    meta_we  = 1'b0;
    slot_we  = 1'b0;
    cnt_new  = cnt_q;
    off_new  = off_q;
    if (!free_q) begin
      if (!valid_q) begin
        st_d = ST_TOO_LARGE;
      end else begin
        open_set = 1'b1;
        meta_we  = 1'b1;
        if (cnt_q != '0) begin
          cnt_new = cnt_q - CNT_W'(1);
          hnd_d   = {slot_rdata, cls_q};
          rsz_d   = rsz_q;
        end else if (rsz_q > ~off_q) begin
          st_d = ST_OVERFLOW;
        end else begin
          off_new = off_q + rsz_q;
          hnd_d   = off_q | SIZE_W'(cls_q);
          rsz_d   = rsz_q;
        end
      end
    end else begin
      if (!valid_q || !opened_q2) begin
        st_d = ST_FREE_IGNORED;
      end else if (cnt_q >= CNT_W'(LIST_DEPTH)) begin
        st_d = ST_LIST_FULL;
      end else begin
        slot_we = 1'b1;
        meta_we = 1'b1;
        cnt_new = cnt_q + CNT_W'(1);
      end
    end
    meta_we    = meta_we && cmd_i.commit;
    slot_we    = slot_we && cmd_i.commit;
    meta_wdata = {off_new, cnt_new};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opened_q <= '0;
    end else if (cmd_i.commit && open_set) begin
      opened_q[cls_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hnd_q     <= hnd_d;
      rsz_out_q <= rsz_d;
      st_q      <= st_d;
    end
  end

  assign handle_o       = hnd_q;
  assign rounded_size_o = rsz_out_q;
  assign status_o       = st_q;

endmodule

`default_nettype wire

// ===== design/size_class_block_allocator.sv =====
// top level of the segregated size class block allocator
// depends on sca_pkg, sca_if, sca_ctrl, sca_dp and sca_ram
//
//   channel  dir  payload                              transfer when
//   req_i    in   req_type, alloc_size, free_handle    valid && ready
//   rsp_o    out  handle, rounded_size, status         valid && ready
//
// a request passes from transfer to result through capture, size normalise,
// class map with metadata ram read, free list ram read, commit
// the next request is taken the cycle after commit, so only one request is in flight at a time
// reset clears the opened bits at once; ram contents are qualified by them
// a waiting result holds commit back only while it has not been taken

`default_nettype none

module size_class_block_allocator #(
  parameter int unsigned NUM_CLASSES = 160,
  parameter int unsigned LIST_DEPTH  = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sca_req_if.sink    req_i,
  sca_rsp_if.source  rsp_o
);
  import sca_pkg::*;

  sca_cmd_t cmd;

  sca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  sca_dp #(
    .NUM_CLASSES (NUM_CLASSES),
    .LIST_DEPTH  (LIST_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .req_type_i     (req_i.req_type),
    .alloc_size_i   (req_i.alloc_size),
    .free_handle_i  (req_i.free_handle),
    .handle_o       (rsp_o.handle),
    .rounded_size_o (rsp_o.rounded_size),
    .status_o       (rsp_o.status)
  );

endmodule

`default_nettype wire

// ===== design/sca_checker.sv =====
// port level checks for the size class allocator, bound to the top level
// depends on sca_pkg and sca_if

`default_nettype none

module sca_checker #(
  parameter int unsigned NUM_CLASSES = 160
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sca_req_if.sink    req_i,
  sca_rsp_if.source  rsp_i
);
  import sca_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_i.valid && !rsp_i.ready |=> rsp_i.valid && $stable(rsp_i.handle)
      && $stable(rsp_i.status))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request taken while one is in flight");

  a_fail_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_i.valid && rsp_i.status != ST_OK |-> rsp_i.handle == '1
      && rsp_i.rounded_size == '0)
    else $error("failed request carries a payload");

  a_alloc_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_i.valid && rsp_i.status == ST_OK && rsp_i.handle != '1
      |-> {1'b0, rsp_i.handle[CLASS_W-1:0]} < (CLASS_W + 1)'(NUM_CLASSES)
      && rsp_i.rounded_size[7:0] == 8'h00)
    else $error("allocated handle has a bad class or size");

endmodule

bind size_class_block_allocator sca_checker #(
  .NUM_CLASSES (NUM_CLASSES)
) u_sca_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req_i  (req_i),
  .rsp_i  (rsp_o)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the size class block allocator
// depends on sca_pkg, sca_if and size_class_block_allocator; predicts every response
// from its own copy of the class tables and compares it with the block's output

`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sca_pkg::*;

  localparam int unsigned CLASSES      = 160;
  localparam int unsigned DEPTH        = 64;
  localparam int unsigned TOP_CLASS    = CLASSES - 1;
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned MIXED_ITEMS  = 1900;
  localparam int unsigned BUMP_RUN     = 50;
  localparam int unsigned BACKLOG_MAX  = 4;
  localparam int unsigned POOL_MAX     = 512;
  localparam logic [63:0] ALL_ONES     = '1;

  typedef struct {
    sca_req_e    kind;
    logic [63:0] size;
    logic [63:0] handle;
    int unsigned gap_max;
  } block_req_t;

  typedef struct {
    logic [63:0] handle;
    logic [63:0] rounded;
    sca_status_e status;
  } block_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sca_req_if req_if ();
  sca_rsp_if rsp_if ();

  size_class_block_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the class tables
  bit          opened  [CLASSES];
  logic [63:0] bump    [CLASSES];
  int unsigned stacked [CLASSES];
  logic [55:0] parked  [CLASSES][DEPTH];

  block_req_t  req_backlog [$];
  block_rsp_t  awaited_rsp [$];
  logic [63:0] live_handles [$];

  block_req_t  on_bus;
  int unsigned gap_max;
  int unsigned gap_left;
  bit          gap_drawn;
  int unsigned offered;
  int unsigned accepted;
  int unsigned responses;
  int unsigned stall_max;
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned pick_gap_max();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 4;
      default: return 16;
    endcase
  endfunction

  function automatic logic [63:0] class_bytes(int unsigned c);
    logic [63:0] base;
    base = 64'd1024 + 64'(c % 4) * 64'd256;
    return base << (c / 4);
  endfunction

  function automatic int unsigned class_of(logic [63:0] size);
    logic [63:0] s1;
    int unsigned msb;
    int unsigned a;
    if (size <= 64'd1024) return 0;
    s1  = size - 64'd1;
    msb = 0;
    for (int i = 0; i < 64; i++) begin
      if (s1[i]) msb = i;
    end
    a = msb - 10;
    return a * 4 + 32'((s1 >> (a + 8)) & 64'd3) + 1;
  endfunction

  function automatic logic [63:0] size_in_class(int unsigned c);
    logic [63:0] lo;
    if (c == 0) return rand64() % 64'd1025;
    lo = class_bytes(c - 1);
    return lo + 64'd1 + rand64() % (class_bytes(c) - lo);
  endfunction

  function automatic block_rsp_t serve_request(block_req_t r);
    block_rsp_t  o;
    int unsigned c;
    logic [63:0] off;
    logic [63:0] span;
    o.handle  = ALL_ONES;
    o.rounded = '0;
    o.status  = ST_OK;
    if (r.kind == REQ_ALLOC) begin
      c = class_of(r.size);
      if (c >= CLASSES) begin
        o.status = ST_TOO_LARGE;
        return o;
      end
      span      = class_bytes(c);
      opened[c] = 1'b1;
      if (stacked[c] > 0) begin
        stacked[c]--;
        off = {parked[c][stacked[c]], 8'h00};
      end else begin
        off = bump[c];
        if (span > ~off) begin
          o.status = ST_OVERFLOW;
          return o;
        end
        bump[c] = off + span;
      end
      o.handle  = off | 64'(c);
      o.rounded = span;
      if (live_handles.size() < POOL_MAX) live_handles = {live_handles, o.handle};
    end else begin
      c = 32'(r.handle[7:0]);
      if (c >= CLASSES || !opened[c]) begin
        o.status = ST_FREE_IGNORED;
      end else if (stacked[c] >= DEPTH) begin
        o.status = ST_LIST_FULL;
      end else begin
        parked[c][stacked[c]] = r.handle[63:8];
        stacked[c]++;
      end
    end
    return o;
  endfunction

  function automatic logic [63:0] take_live();
    int unsigned i;
    logic [63:0] h;
    i = $urandom_range(0, live_handles.size() - 1);
    h = live_handles[i];
    live_handles.delete(i);
    return h;
  endfunction

  task automatic offer(sca_req_e kind, logic [63:0] size, logic [63:0] handle);
    block_req_t r;
    while (req_backlog.size() >= BACKLOG_MAX) @(posedge clk_i);
    r.kind    = kind;
    r.size    = size;
    r.handle  = handle;
    r.gap_max = gap_max;
    req_backlog = {req_backlog, r};
    offered++;
  endtask

  task automatic mixed_traffic(int unsigned upto, bit flood_first);
    logic [63:0] h;
    int unsigned c;
    int unsigned kind;
    bit          first;
    first = flood_first;
    while (offered < upto) begin
      if ($urandom_range(0, 63) == 0) gap_max = pick_gap_max();
      kind  = first ? 99 : $urandom_range(0, 99);
      first = 1'b0;
      if (kind < 45 || (kind < 75 && live_handles.size() == 0)) begin
        c = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 15) : $urandom_range(0, TOP_CLASS);
        case ($urandom_range(0, 9))
          0: h = class_bytes(c);
          1: h = (c == 0) ? 64'd0 : class_bytes(c - 1) + 64'd1;
          default: h = size_in_class(c);
        endcase
        offer(REQ_ALLOC, h, rand64());
      end else if (kind < 75) begin
        offer(REQ_FREE, rand64(), take_live());
      end else if (kind < 80) begin
        h = class_bytes(TOP_CLASS);
        offer(REQ_ALLOC, h + 64'd1 + rand64() % (ALL_ONES - h), rand64());
      end else if (kind < 90) begin
        offer(REQ_FREE, rand64(), rand64());
      end else if (kind < 95) begin
        // foreign offset pushed into a small class
        h      = rand64();
        h[7:0] = 8'($urandom_range(0, 7));
        offer(REQ_FREE, rand64(), h);
      end else begin
        // overfill one free list, then pop part of it back
        c = $urandom_range(0, 15);
        offer(REQ_ALLOC, size_in_class(c), rand64());
        repeat ($urandom_range(DEPTH + 1, DEPTH + 6)) begin
          h      = rand64();
          h[7:0] = 8'(c);
          offer(REQ_FREE, rand64(), h);
        end
        repeat ($urandom_range(2, 10)) offer(REQ_ALLOC, size_in_class(c), rand64());
      end
    end
  endtask

  always @(posedge clk_i) begin : drive_requests
    logic       drive;
    block_rsp_t next_rsp;
    drive = req_if.valid;
    if (!rst_ni) begin
      drive = 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        next_rsp    = serve_request(on_bus);
        awaited_rsp = {awaited_rsp, next_rsp};
        accepted++;
        drive = 1'b0;
      end
      if (!drive && req_backlog.size() > 0) begin
        if (!gap_drawn) begin
          gap_left  = $urandom_range(0, req_backlog[0].gap_max);
          gap_drawn = 1'b1;
        end
        if (gap_left == 0) begin
          on_bus    = req_backlog.pop_front();
          gap_drawn = 1'b0;
          drive     = 1'b1;
        end else begin
          gap_left--;
        end
      end
    end
    req_if.valid       <= drive;
    req_if.req_type    <= on_bus.kind;
    req_if.alloc_size  <= on_bus.size;
    req_if.free_handle <= on_bus.handle;
  end

  always @(posedge clk_i) begin : check_responses
    block_rsp_t want;
    logic       take;
    take = 1'b0;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (awaited_rsp.size() == 0) begin
          $error("response without outstanding request: handle %h", rsp_if.handle);
          mismatches++;
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp_if.handle !== want.handle) begin
            $error("handle: expected %h, got %h", want.handle, rsp_if.handle);
            mismatches++;
          end
          if (rsp_if.rounded_size !== want.rounded) begin
            $error("rounded_size: expected %h, got %h", want.rounded, rsp_if.rounded_size);
            mismatches++;
          end
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_if.status);
            mismatches++;
          end
        end
        responses++;
        if (responses % 64 == 0) stall_max = pick_gap_max();
        // long back-pressure so the request side stalls
        if (responses == 150) hold_left = HOLD_CYCLES;
        stall_left = $urandom_range(0, stall_max);
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end else begin
        take = 1'b1;
      end
    end
    rsp_if.ready <= take;
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    req_if.valid       = 1'b0;
    req_if.req_type    = REQ_ALLOC;
    req_if.alloc_size  = '0;
    req_if.free_handle = '0;
    rsp_if.ready       = 1'b0;
    on_bus             = '{REQ_ALLOC, 64'd0, 64'd0, 0};
    gap_max            = 3;
    gap_left           = 0;
    gap_drawn          = 1'b0;
    offered            = 0;
    accepted           = 0;
    responses          = 0;
    stall_max          = 4;
    stall_left         = 0;
    hold_left          = 0;
    mismatches         = 0;
    quiet_cycles       = 0;
    for (int c = 0; c < CLASSES; c++) begin
      opened[c]  = 1'b0;
      bump[c]    = '0;
      stacked[c] = 0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    offer(REQ_ALLOC, 64'd0, ALL_ONES);
    offer(REQ_ALLOC, 64'd1024, rand64());
    offer(REQ_ALLOC, 64'd1025, rand64());
    offer(REQ_ALLOC, class_bytes(TOP_CLASS), 64'd0);
    offer(REQ_ALLOC, class_bytes(TOP_CLASS) + 64'd1, rand64());
    offer(REQ_ALLOC, ALL_ONES, rand64());
    offer(REQ_ALLOC, 64'h8000_0000_0000_0000, rand64());
    offer(REQ_FREE, ALL_ONES, 64'd0);
    offer(REQ_ALLOC, 64'd1, rand64());
    offer(REQ_FREE, rand64(), {56'h12_3456_789a_bcde, 8'd200});
    offer(REQ_FREE, rand64(), ALL_ONES);
    offer(REQ_FREE, rand64(), {56'd4, 8'd37});
    offer(REQ_FREE, rand64(), {56'd1, 8'd160});
    offer(REQ_FREE, rand64(), {56'hff_ffff_ffff_ffff, 8'd1});
    offer(REQ_ALLOC, 64'd1100, rand64());
    offer(REQ_ALLOC, 64'd1100, rand64());
    offer(REQ_FREE, rand64(), {56'd0, 8'(TOP_CLASS)});
    offer(REQ_ALLOC, class_bytes(TOP_CLASS - 1) + 64'd1, rand64());
    offer(REQ_ALLOC, class_bytes(TOP_CLASS - 1), rand64());

    mixed_traffic(MIXED_ITEMS / 2, 1'b1);

    // back to back allocations from the top class
    gap_max = 0;
    repeat (BUMP_RUN) offer(REQ_ALLOC, size_in_class(TOP_CLASS), rand64());
    offer(REQ_FREE, rand64(), {56'h5, 8'(TOP_CLASS)});
    offer(REQ_ALLOC, class_bytes(TOP_CLASS), rand64());
    offer(REQ_ALLOC, class_bytes(TOP_CLASS), rand64());
    if (live_handles.size() > 0) offer(REQ_FREE, rand64(), take_live());
    gap_max = pick_gap_max();

    mixed_traffic(offered + MIXED_ITEMS / 2, 1'b0);

    while (accepted != offered) @(posedge clk_i);
    while (awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
